/* hdl/sgr_pkg.sv */
package sgr_pkg;

	// Width of one list element.
	localparam int unsigned DATA_W = 32;

	// Width of the group size register.
	localparam int unsigned GS_W = 5;

	// Widths that cover every supported maximum group size (up to 64).
	localparam int unsigned CNT_W = 7;
	localparam int unsigned IDX_W = 6;

	// Configuration port: byte address width and register word indexes.
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_GROUP_SIZE = 1'b0;

	// Reset value of the group size register.
	localparam logic [GS_W-1:0] GS_RESET = 5'd1;

	// One input item.
	typedef struct packed {
		logic signed [DATA_W-1:0] elem_value;
		logic                     list_end;
	} in_t;

	// One result item.
	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic                     burst_last;
		logic                     out_list_end;
	} out_t;

	// Emission command handed from the front to the back.
	typedef struct packed {
		logic             bank;
		logic             reverse;
		logic             list_end;
		logic [CNT_W-1:0] count;
	} cmd_t;

	// Buffer write from the front into the back's memory.
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} wr_t;

	// Bank release from the back once a group has been read out.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

/* hdl/sgr_front.sv */
module sgr_front #(
	parameter int unsigned MAX_GROUP = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sgr_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// Input channel
	input  logic                            item_valid,
	output logic                            item_ready,
	input  sgr_pkg::in_t                    item,
	// Command queue
	output logic                            cmd_push,
	output sgr_pkg::cmd_t                   cmd,
	input  logic                            cmd_full,
	// Buffer write and bank release
	output sgr_pkg::wr_t                    wr,
	input  sgr_pkg::rel_t                   rel
);

	localparam int unsigned FW = $clog2(MAX_GROUP + 1);
	localparam int unsigned CW = (FW > sgr_pkg::GS_W) ? FW : sgr_pkg::GS_W;

	logic [sgr_pkg::GS_W-1:0] gs_q;
	logic [FW-1:0]            fill_q;
	logic                     bank_q;
	logic [1:0]               busy_q;

	logic                     cfg_wr;
	logic                     accept;
	logic [FW-1:0]            new_fill;
	logic [CW-1:0]            gs_ext;
	logic [CW-1:0]            k_eff;
	logic                     reverse;
	logic                     emit;

	// Register access: writes complete in the access phase, no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[sgr_pkg::ADDR_W-1] == sgr_pkg::REG_GROUP_SIZE);

	always_comb begin
		prdata = '0;
		if (paddr[sgr_pkg::ADDR_W-1] == sgr_pkg::REG_GROUP_SIZE) begin
			prdata = 32'(gs_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= sgr_pkg::GS_RESET;
		end else if (cfg_wr) begin
			gs_q <= pwdata[sgr_pkg::GS_W-1:0];
		end
	end

	// Effective group size: zero acts as one, large values saturate.
	always_comb begin
		gs_ext = CW'(gs_q);
		if (gs_ext == '0) begin
			k_eff = CW'(1);
		end else if (gs_ext > CW'(MAX_GROUP)) begin
			k_eff = CW'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end

	// Classify the incoming element.
	assign item_ready = !busy_q[bank_q] && !cmd_full;
	assign accept     = item_valid && item_ready;
	assign new_fill   = fill_q + FW'(1);
	assign reverse    = CW'(new_fill) >= k_eff;
	assign emit       = reverse || item.list_end;

	// Element goes straight into the current bank.
	always_comb begin
		wr.en   = accept;
		wr.bank = bank_q;
		wr.idx  = sgr_pkg::IDX_W'(fill_q);
		wr.data = item.elem_value;
	end

	// Command for the back once a burst is due.
	always_comb begin
		cmd_push     = accept && emit;
		cmd.bank     = bank_q;
		cmd.reverse  = reverse;
		cmd.list_end = item.list_end;
		cmd.count    = sgr_pkg::CNT_W'(new_fill);
	end

	// Fill count, bank selection and bank ownership.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (accept) begin
				if (emit) begin
					fill_q         <= '0;
					bank_q         <= !bank_q;
					busy_q[bank_q] <= 1'b1;
				end else begin
					fill_q <= new_fill;
				end
			end
		end
	end

endmodule

/* hdl/sgr_cmd_fifo.sv */
module sgr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sgr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output sgr_pkg::cmd_t pop_cmd,
	output logic          empty
);

	sgr_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    level_q;

	assign full    = (level_q == 2'd2);
	assign empty   = (level_q == 2'd0);
	assign pop_cmd = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

/* hdl/sgr_back.sv */
module sgr_back #(
	parameter int unsigned MAX_GROUP = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	// Buffer write from the front
	input  sgr_pkg::wr_t  wr,
	// Command queue
	output logic          cmd_pop,
	input  sgr_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	// Bank release to the front
	output sgr_pkg::rel_t rel,
	// Result channel
	output logic          result_valid,
	input  logic          result_ready,
	output sgr_pkg::out_t result
);

	localparam int unsigned FW = $clog2(MAX_GROUP + 1);
	localparam int unsigned IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [sgr_pkg::DATA_W-1:0] mem_q [2][MAX_GROUP];

	sgr_pkg::cmd_t              cur_q;
	logic                       active_q;
	logic [FW-1:0]              rd_idx_q;

	logic                       s1_valid_q;
	logic [sgr_pkg::DATA_W-1:0] rdata_s1;
	logic                       last_s1;
	logic                       end_s1;

	logic                       out_valid_q;
	sgr_pkg::out_t              out_q;

	sgr_pkg::rel_t              rel_q;

	logic [FW-1:0]              count;
	logic [FW-1:0]              src;
	logic                       last_rd;
	logic                       s1_move;
	logic                       issue;

	// Read sequencing over the current group.
	assign count   = FW'(cur_q.count);
	assign src     = cur_q.reverse ? (count - FW'(1) - rd_idx_q) : rd_idx_q;
	assign last_rd = (rd_idx_q + FW'(1)) == count;
	assign s1_move = s1_valid_q && (!out_valid_q || result_ready);
	assign issue   = active_q && (!s1_valid_q || s1_move);
	assign cmd_pop = !active_q && !cmd_empty;

	// Group buffer, two banks: one fills while the other drains.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.bank][wr.idx[IW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem_q[cur_q.bank][src[IW-1:0]];
			last_s1  <= last_rd;
			end_s1   <= last_rd && cur_q.list_end;
		end
	end

	// Command pick-up and read index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rd_idx_q <= '0;
			rel_q    <= '0;
		end else begin
			rel_q.valid <= 1'b0;
			if (cmd_pop) begin
				active_q <= 1'b1;
				rd_idx_q <= '0;
			end else if (issue) begin
				if (last_rd) begin
					active_q    <= 1'b0;
					rel_q.valid <= 1'b1;
					rel_q.bank  <= cur_q.bank;
				end else begin
					rd_idx_q <= rd_idx_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	// Read data stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.out_value    <= rdata_s1;
			out_q.burst_last   <= last_s1;
			out_q.out_list_end <= end_s1;
		end
	end

	assign rel          = rel_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* hdl/stream_group_reverser.sv */
// Stream group reverser. Elements arrive one per transfer and are written into one of two
// buffer banks; once group_size elements are held (or the list ends early) the group is read
// back out, reversed for a full group and in arrival order for a short tail, one result per
// cycle while the receiver does not stall. An element is taken whenever the bank being filled
// is free and the command queue has room, so a new group fills while the previous one drains
// from the other bank. Each group begins with a command pick-up, and its results are read out
// through the single read port of the buffer. No clearing pass is needed after reset.
module stream_group_reverser #(
	parameter int unsigned MAX_GROUP = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sgr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// Input channel
	input  logic                       item_valid,
	output logic                       item_ready,
	input  sgr_pkg::in_t               item,
	// Result channel
	output logic                       result_valid,
	input  logic                       result_ready,
	output sgr_pkg::out_t              result
);

	logic          cmd_push;
	logic          cmd_pop;
	logic          cmd_full;
	logic          cmd_empty;
	sgr_pkg::cmd_t push_cmd;
	sgr_pkg::cmd_t pop_cmd;
	sgr_pkg::wr_t  wr;
	sgr_pkg::rel_t rel;

	// Front: register, element intake and group classification.
	sgr_front #(
		.MAX_GROUP (MAX_GROUP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_push   (cmd_push),
		.cmd        (push_cmd),
		.cmd_full   (cmd_full),
		.wr         (wr),
		.rel        (rel)
	);

	// Queue of pending bursts between the two halves.
	sgr_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.pop_cmd  (pop_cmd),
		.empty    (cmd_empty)
	);

	// Back: buffer memory and burst read-out.
	sgr_back #(
		.MAX_GROUP (MAX_GROUP)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (wr),
		.cmd_pop      (cmd_pop),
		.cmd          (pop_cmd),
		.cmd_empty    (cmd_empty),
		.rel          (rel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* hdl/sgr_checker.sv */
module sgr_assert_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic [31:0]                prdata,
	input logic                       pready,
	input logic                       result_valid,
	input logic                       result_ready,
	input sgr_pkg::out_t              result
);

	// A stalled result transfer keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The end of the list can only be flagged on the last result of a burst.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.burst_last || !result.out_list_end))
		else $error("list end flagged inside a burst");

	// The register port never inserts wait states.
	assert property (@(posedge clk) pready)
		else $error("pready low");

	// Reads return only the bits of the group size register.
	assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:sgr_pkg::GS_W] == '0)
		else $error("unused read data bits set");

endmodule

bind stream_group_reverser sgr_assert_checker u_sgr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.prdata       (prdata),
	.pready       (pready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* dv/sgr_checker.sv */
// Watches the configuration port and both streaming channels of the group reverser. It keeps
// its own copy of the group buffer and the group size, predicts the results of every element
// transfer, and compares each result transfer with the oldest prediction still due.
module sgr_checker #(
	parameter int unsigned MAX_GROUP = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [sgr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic                       item_valid,
	input  logic                       item_ready,
	input  sgr_pkg::in_t               item,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  sgr_pkg::out_t              result,
	output int                         fail_count,
	output int                         pending
);

	logic [sgr_pkg::DATA_W-1:0] held_values [MAX_GROUP];
	int unsigned                held_count;
	logic [sgr_pkg::GS_W-1:0]   group_size_q;
	sgr_pkg::out_t              due_results [$];
	int                         errors;

	// Hold one element and, once a group is complete or the list ends, queue the emission.
	task automatic predict_group(input sgr_pkg::in_t x);
		int unsigned   k;
		int unsigned   n;
		bit            emit;
		bit            rev;
		sgr_pkg::out_t r;
		k = 32'(group_size_q);
		if (k == 0)
			k = 1;
		if (k > MAX_GROUP)
			k = MAX_GROUP;
		if (held_count < MAX_GROUP) begin
			held_values[held_count] = x.elem_value;
			held_count++;
		end
		emit = 1'b1;
		rev  = 1'b0;
		if (held_count >= k)
			rev = 1'b1;
		else if (!x.list_end)
			emit = 1'b0;
		if (emit) begin
			n = held_count;
			for (int unsigned i = 0; i < n; i++) begin
				r.out_value    = rev ? held_values[n - 1 - i] : held_values[i];
				r.burst_last   = (i + 1 == n);
				r.out_list_end = (i + 1 == n) && x.list_end;
				due_results.push_back(r);
			end
			held_count = 0;
		end
	endtask

	// Compare one result transfer field by field with the oldest prediction.
	task automatic check_result(input sgr_pkg::out_t got);
		sgr_pkg::out_t want;
		if (due_results.size() == 0) begin
			errors++;
			$display("%0t: result transfer with nothing due: value %h burst_last %b list_end %b",
				$time, got.out_value, got.burst_last, got.out_list_end);
		end else begin
			want = due_results.pop_front();
			if (got.out_value !== want.out_value) begin
				errors++;
				$display("%0t: out_value mismatch: expected %h, actual %h",
					$time, want.out_value, got.out_value);
			end
			if (got.burst_last !== want.burst_last) begin
				errors++;
				$display("%0t: burst_last mismatch: expected %b, actual %b",
					$time, want.burst_last, got.burst_last);
			end
			if (got.out_list_end !== want.out_list_end) begin
				errors++;
				$display("%0t: out_list_end mismatch: expected %b, actual %b",
					$time, want.out_list_end, got.out_list_end);
			end
		end
	endtask

	// Results are checked before new elements are predicted, as a result leaving at this edge
	// cannot come from an element arriving at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count   = 0;
			group_size_q = sgr_pkg::GS_RESET;
			due_results.delete();
			errors       = 0;
			fail_count  <= 0;
			pending     <= 0;
		end else begin
			if (result_valid && result_ready)
				check_result(result);
			if (psel && penable && pwrite && pready
				&& paddr[sgr_pkg::ADDR_W-1:2] == sgr_pkg::REG_GROUP_SIZE)
				group_size_q = pwdata[sgr_pkg::GS_W-1:0];
			if (item_valid && item_ready)
				predict_group(item);
			fail_count <= errors;
			pending    <= due_results.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// Drives the group reverser with directed and random element lists under a range of group
// sizes, with random gaps on both channels, and reports the checker's verdict.
module tb_top;

	localparam int unsigned MAX_GROUP   = 16;
	localparam int          ITEM_TARGET = 430;
	localparam int          LONG_HOLD   = 300;
	localparam int          SETTLE      = 8;
	localparam int          TAIL        = 20;
	// Register index with nothing behind it.
	localparam logic        REG_UNUSED  = 1'b1;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       psel          = 1'b0;
	logic                       penable       = 1'b0;
	logic                       pwrite        = 1'b0;
	logic [sgr_pkg::ADDR_W-1:0] paddr         = '0;
	logic [31:0]                pwdata        = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       item_valid    = 1'b0;
	logic                       item_ready;
	sgr_pkg::in_t               item          = '0;
	logic                       result_valid;
	logic                       result_ready  = 1'b0;
	sgr_pkg::out_t              result;
	logic                       long_hold_req = 1'b0;
	int                         fail_count;
	int                         pending;
	int                         sent_count    = 0;
	bit                         tx_quiet      = 1'b0;

	always #4 clk = ~clk;

	stream_group_reverser #(
		.MAX_GROUP(MAX_GROUP)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	sgr_checker #(
		.MAX_GROUP(MAX_GROUP)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Setup cycle, then access cycles until pready is seen, then back to idle.
	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one element after a random gap and hold it until the transfer takes place.
	task automatic send_item(input logic [31:0] value, input logic last);
		int gap;
		int r;
		gap = 0;
		if (!tx_quiet) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{elem_value: value, list_end: last};
		do @(posedge clk); while (!item_ready);
		sent_count++;
	endtask

	// Stop offering, wait for every due result, then let the block settle.
	task automatic finish_phase();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Receiver: random stalls with quiet stretches, and one long hold-off on request.
	initial begin
		int  stall_left;
		int  rx_cycles;
		int  r;
		bit  rx_quiet;
		bit  hold_taken;
		stall_left = 0;
		rx_cycles  = 0;
		rx_quiet   = 1'b0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_taken) begin
				hold_taken    = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (!rx_quiet && r < 15)
					stall_left = $urandom_range(1, 3);
				else if (!rx_quiet && r < 18)
					stall_left = $urandom_range(10, 40);
			end
			rx_cycles++;
			if (rx_cycles % 64 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	// Safety net against a hung run.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int              gs;
		logic [31:0]     data;
		int              eff;
		int              r;
		int              nlists;
		int              len;
		int              phase_no;
		bit              noisy;
		bit              open_tail;
		bit              last;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset group size of one: value extremes pass straight through.
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1);
		finish_phase();

		// A write to the unused register index must leave the group size alone.
		write_reg(REG_UNUSED, 32'd5);
		send_item(32'h1234_5678, 1'b1);
		finish_phase();

		// Two elements held under a group of three, then the size drops to two mid-group,
		// so all three held elements leave reversed.
		write_reg(sgr_pkg::REG_GROUP_SIZE, 32'd3);
		send_item(32'h0000_0011, 1'b0);
		send_item(32'h0000_0022, 1'b0);
		finish_phase();
		write_reg(sgr_pkg::REG_GROUP_SIZE, 32'd2);
		send_item(32'h0000_0033, 1'b0);
		// A one-element tail, then a group completed by the element that ends the list.
		send_item(32'h0000_0044, 1'b1);
		send_item(32'h0000_0055, 1'b0);
		send_item(32'h0000_0066, 1'b1);
		finish_phase();

		// A group size of zero behaves as one.
		write_reg(sgr_pkg::REG_GROUP_SIZE, 32'd0);
		send_item(32'hA5A5_A5A5, 1'b0);
		send_item(32'h5A5A_5A5A, 1'b0);
		finish_phase();

		// A size above the maximum saturates; a short list leaves in arrival order.
		write_reg(sgr_pkg::REG_GROUP_SIZE, 32'd31);
		send_item(32'h0000_0001, 1'b0);
		send_item(32'h0000_0002, 1'b0);
		send_item(32'h0000_0003, 1'b1);
		finish_phase();

		// Random phases: a group size per phase, then mostly well-formed lists.
		phase_no = 0;
		while (sent_count < ITEM_TARGET) begin
			r = $urandom_range(0, 19);
			if (phase_no == 2)
				gs = 4;
			else if (r == 0)
				gs = 0;
			else if (r == 1)
				gs = $urandom_range(17, 31);
			else if (r == 2)
				gs = 16;
			else if (r == 3)
				gs = 1;
			else
				gs = $urandom_range(2, 15);
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, $urandom());
			data                    = $urandom();
			data[sgr_pkg::GS_W-1:0] = gs[sgr_pkg::GS_W-1:0];
			write_reg(sgr_pkg::REG_GROUP_SIZE, data);
			eff = (gs == 0) ? 1 : ((gs > MAX_GROUP) ? MAX_GROUP : gs);
			tx_quiet = ($urandom_range(0, 3) == 0);

			if (phase_no == 2) begin
				// Receiver holds off while a long list keeps arriving, filling the block.
				long_hold_req <= 1'b1;
				for (int i = 0; i < 60; i++)
					send_item($urandom(), i == 59);
			end else begin
				nlists = $urandom_range(1, 3);
				for (int l = 0; l < nlists; l++) begin
					if ($urandom_range(0, 9) == 0)
						len = $urandom_range(1, 40);
					else
						len = $urandom_range(1, 2 * eff + 1);
					noisy     = ($urandom_range(0, 6) == 0);
					open_tail = (l == nlists - 1) && ($urandom_range(0, 3) == 0);
					for (int i = 0; i < len; i++) begin
						if (noisy)
							last = ($urandom_range(0, 3) == 0);
						else
							last = (i == len - 1) && !open_tail;
						send_item($urandom(), last);
					end
				end
			end
			finish_phase();
			phase_no++;
		end

		repeat (TAIL) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
